[rtl/position_divergence_histogram_macros.svh]
// ----------------------------------------------------------------------------
// position divergence histogram assertion macros
// shared concurrent checks for the histogram rtl
// ----------------------------------------------------------------------------
`ifndef POSITION_DIVERGENCE_HISTOGRAM_MACROS_SVH
`define POSITION_DIVERGENCE_HISTOGRAM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PDH_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pdh check failed");

// condition must never hold
`define PDH_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pdh check failed");

`endif

[rtl/pdh_pkg.sv]
// ----------------------------------------------------------------------------
// pdh_pkg
// commands, register indexes, cordic table and the per-beat side data
// ----------------------------------------------------------------------------
package pdh_pkg;

  // command codes
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_BLOCK = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_POS_LO = 3'd1;
  localparam logic [2:0] REG_POS_HI = 3'd2;
  localparam logic [2:0] REG_ANG_LO = 3'd3;
  localparam logic [2:0] REG_ANG_HI = 3'd4;
  localparam logic [2:0] REG_WL_WIN = 3'd5;
  localparam logic [2:0] REG_Y_WIN  = 3'd6;
  localparam logic [2:0] REG_Z_WIN  = 3'd7;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 16;

  // arctangent of 2^-i in q16.16 degrees
  localparam logic signed [31:0] ATAN_DEG [CORDIC_STEPS] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
    32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
    32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
    32'sd917,     32'sd458,     32'sd229,    32'sd115
  };

  localparam logic signed [31:0] DEG180   = 32'sd11796480;
  localparam logic [31:0]        ONE_Q16  = 32'h0001_0000;
  localparam logic [31:0]        CNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [47:0]        INT_MAX  = 48'hFFFF_FFFF_FFFF;

  // data that rides along the whole pipeline
  typedef struct packed {
    logic [1:0]         cmd;
    logic               pass;
    logic signed [31:0] pos;
    logic [31:0]        add;
    logic [11:0]        raddr;
    logic               negd;
    logic               nums;
  } side_t;

endpackage

[rtl/position_divergence_histogram.sv]
// ----------------------------------------------------------------------------
// position_divergence_histogram
// position against divergence angle histogram with saturating bins
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i / in_stall_o carries one command per beat:
//   particle event, block end marker or bin read. output channel
//   out_valid_o / out_stall_i returns exactly one result beat per input beat,
//   in order.
//   a beat may enter every cycle while in_stall_o is low. the pipeline
//   depth comes from the 16-step square root, the 16-step cordic and one
//   quotient bit per stage of the bin divider, D bits wide, D being clog2
//   of the larger of POS_BINS and ANGLE_BINS.
//   events update the bin memory by read-modify-write with forwarding from
//   the write stage, so back-to-back hits on one bin are exact.
//   after reset the bin memory is cleared one entry per cycle, through all
//   POS_BINS*ANGLE_BINS entries; in_stall_o is high for that time, register
//   writes are taken as ever.
//   when out_stall_i holds a valid result the whole pipeline freezes and
//   in_stall_o rises; nothing is lost or repeated.
//   configuration must be written only when the pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "position_divergence_histogram_macros.svh"

module position_divergence_histogram #(
  parameter int unsigned POS_BINS   = 64,
  parameter int unsigned ANGLE_BINS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [31:0]         wavelength_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [15:0]  dir_z_i,
  input  logic [31:0]         weight_i,
  input  logic [11:0]         bin_address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                forward_o,
  output logic                registered_o,
  output logic [31:0]         read_count_o,
  output logic [47:0]         read_intensity_o
);
  import pdh_pkg::*;

  localparam int unsigned NBINS = POS_BINS * ANGLE_BINS;
  localparam int unsigned AW = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int unsigned PW = (POS_BINS > 1) ? $clog2(POS_BINS) : 1;
  localparam int unsigned QW = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
  localparam int unsigned DW = (PW > QW) ? PW : QW;
  // stage numbers
  localparam int unsigned G_SQ = SQRT_STEPS;
  localparam int unsigned G_CO = G_SQ + CORDIC_STEPS;
  localparam int unsigned G_P1 = G_CO + 1;
  localparam int unsigned G_P2 = G_P1 + 1;
  localparam int unsigned G_P3 = G_P2 + 1;
  localparam int unsigned G_DV = G_P3 + DW;
  localparam int unsigned G_A  = G_DV + 1;
  localparam int unsigned G_W  = G_A + 1;
  localparam int unsigned NS   = G_W + 1;
  localparam logic signed [9:0] PBS = 10'(POS_BINS);
  localparam logic signed [9:0] ABS = 10'(ANGLE_BINS);

  // configuration registers
  logic [4:0]         mode_q;
  logic signed [31:0] plo_q, phi_q, alo_q, ahi_q;
  logic [63:0]        wlw_q, yw_q, zw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 5'd2;
      plo_q  <= '0;
      phi_q  <= '0;
      alo_q  <= '0;
      ahi_q  <= '0;
      wlw_q  <= '0;
      yw_q   <= 64'h7FFF_FFFF_8000_0000;
      zw_q   <= 64'h7FFF_FFFF_8000_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q <= cfg_wdata_i[4:0];
        REG_POS_LO: plo_q  <= cfg_wdata_i[31:0];
        REG_POS_HI: phi_q  <= cfg_wdata_i[31:0];
        REG_ANG_LO: alo_q  <= cfg_wdata_i[31:0];
        REG_ANG_HI: ahi_q  <= cfg_wdata_i[31:0];
        REG_WL_WIN: wlw_q  <= cfg_wdata_i;
        REG_Y_WIN:  yw_q   <= cfg_wdata_i;
        REG_Z_WIN:  zw_q   <= cfg_wdata_i;
        default:    mode_q <= mode_q;
      endcase
    end
  end

  // pipeline control
  logic        vld_q [NS];
  side_t       side_q [NS];
  logic        o_vld_q;
  logic        clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic        adv;
  logic        in_acc;

  assign adv        = !(o_vld_q && out_stall_i);
  assign in_stall_o = clr_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_acc;
      for (int k = 1; k < NS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // input stage: filters, axis select, squared radius
  side_t              s0;
  logic signed [31:0] sq_a, sq_b;
  logic               z_ax;
  logic               wl_ok, y_ok, z_ok;
  logic [31:0]        sq0_q;
  logic signed [15:0] num0_q;

  always_comb begin
    z_ax  = mode_q[0];
    wl_ok = !(mode_q[3] && (wavelength_i < wlw_q[31:0])) &&
            !(mode_q[4] && (wavelength_i > wlw_q[63:32]));
    y_ok  = (pos_y_i >= $signed(yw_q[31:0])) && (pos_y_i <= $signed(yw_q[63:32]));
    z_ok  = (pos_z_i >= $signed(zw_q[31:0])) && (pos_z_i <= $signed(zw_q[63:32]));
    sq_a  = dir_x_i * dir_x_i;
    sq_b  = z_ax ? (dir_y_i * dir_y_i) : (dir_z_i * dir_z_i);
    s0.cmd   = command_i;
    s0.pass  = wl_ok && y_ok && z_ok;
    s0.pos   = z_ax ? pos_z_i : pos_y_i;
    s0.add   = mode_q[1] ? weight_i : ONE_Q16;
    s0.raddr = bin_address_i;
    s0.negd  = !z_ax && dir_x_i[15];
    s0.nums  = z_ax ? dir_z_i[15] : dir_y_i[15];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s0;
      sq0_q     <= 32'(sq_a) + 32'(sq_b);
      num0_q    <= z_ax ? dir_z_i : dir_y_i;
      for (int k = 1; k < NS; k++) side_q[k] <= side_q[k-1];
    end
  end

  // square root, one result bit per stage
  logic [31:0]        sv_q [SQRT_STEPS+1];
  logic [31:0]        sr_q [SQRT_STEPS+1];
  logic signed [15:0] sn_q [SQRT_STEPS+1];

  assign sv_q[0] = sq0_q;
  assign sr_q[0] = '0;
  assign sn_q[0] = num0_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [31:0] BIT = 32'(1) << (30 - 2 * k);
    logic [32:0] trial;
    assign trial = 33'(sr_q[k]) + 33'(BIT);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sn_q[k+1] <= sn_q[k];
        if (33'(sv_q[k]) >= trial) begin
          sv_q[k+1] <= sv_q[k] - 32'(trial);
          sr_q[k+1] <= (sr_q[k] >> 1) + BIT;
        end else begin
          sv_q[k+1] <= sv_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
      end
    end
  end

  // cordic vectoring, one micro-rotation per stage
  logic signed [35:0] cx_q [CORDIC_STEPS+1];
  logic signed [35:0] cy_q [CORDIC_STEPS+1];
  logic signed [31:0] cz_q [CORDIC_STEPS+1];
  logic               cneg_q [CORDIC_STEPS+1];

  assign cx_q[0]   = $signed({4'b0, sr_q[SQRT_STEPS][15:0], 16'b0});
  assign cy_q[0]   = $signed({{4{sn_q[SQRT_STEPS][15]}}, sn_q[SQRT_STEPS], 16'b0});
  assign cz_q[0]   = '0;
  assign cneg_q[0] = side_q[G_SQ].negd && (sr_q[SQRT_STEPS] != '0);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [35:0] xs, ys;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cneg_q[i+1] <= cneg_q[i];
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + ATAN_DEG[i];
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - ATAN_DEG[i];
        end
      end
    end
  end

  // angle quadrant fix, then bin numerators and spans
  logic signed [31:0] ang_q;
  logic signed [32:0] pv, pd, av, ad;
  logic signed [42:0] pn_q, pm_q, an_q, am_q;
  logic signed [32:0] pd_q, ad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!cneg_q[CORDIC_STEPS]) ang_q <= cz_q[CORDIC_STEPS];
      else if (side_q[G_CO].nums) ang_q <= -DEG180 - cz_q[CORDIC_STEPS];
      else ang_q <= DEG180 - cz_q[CORDIC_STEPS];
    end
  end

  assign pv = 33'(side_q[G_P1].pos) - 33'(plo_q);
  assign pd = 33'(phi_q) - 33'(plo_q);
  assign av = 33'(ang_q) - 33'(alo_q);
  assign ad = 33'(ahi_q) - 33'(alo_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pn_q <= 43'(pv) * 43'(PBS);
      pm_q <= 43'(pd) * 43'(PBS);
      pd_q <= pd;
      an_q <= 43'(av) * 43'(ABS);
      am_q <= 43'(ad) * 43'(ABS);
      ad_q <= ad;
    end
  end

  // sign normalise and range check
  logic [42:0] pr_q [DW+1];
  logic [42:0] ar_q [DW+1];
  logic [32:0] pdn_q [DW+1];
  logic [32:0] adn_q [DW+1];
  logic        pmiss_q [DW+1];
  logic        amiss_q [DW+1];
  logic [DW-1:0] pq_q [DW+1];
  logic [DW-1:0] aq_q [DW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pmiss_q[0] <= (pd_q == '0) ||
                    ((pd_q > 0) && ((pn_q < 0) || (pn_q >= pm_q))) ||
                    ((pd_q < 0) && ((pn_q > 0) || (pn_q <= pm_q)));
      amiss_q[0] <= (ad_q == '0) ||
                    ((ad_q > 0) && ((an_q < 0) || (an_q >= am_q))) ||
                    ((ad_q < 0) && ((an_q > 0) || (an_q <= am_q)));
      pr_q[0]  <= (pd_q < 0) ? $unsigned(-pn_q) : $unsigned(pn_q);
      ar_q[0]  <= (ad_q < 0) ? $unsigned(-an_q) : $unsigned(an_q);
      pdn_q[0] <= (pd_q < 0) ? $unsigned(-pd_q) : $unsigned(pd_q);
      adn_q[0] <= (ad_q < 0) ? $unsigned(-ad_q) : $unsigned(ad_q);
      pq_q[0]  <= '0;
      aq_q[0]  <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    localparam int unsigned B = DW - 1 - k;
    logic [42:0] pt, at;
    assign pt = 43'(pdn_q[k]) << B;
    assign at = 43'(adn_q[k]) << B;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pdn_q[k+1]   <= pdn_q[k];
        adn_q[k+1]   <= adn_q[k];
        pmiss_q[k+1] <= pmiss_q[k];
        amiss_q[k+1] <= amiss_q[k];
        pr_q[k+1]    <= (pr_q[k] >= pt) ? pr_q[k] - pt : pr_q[k];
        ar_q[k+1]    <= (ar_q[k] >= at) ? ar_q[k] - at : ar_q[k];
        pq_q[k+1]    <= pq_q[k] | ((pr_q[k] >= pt) ? (DW'(1) << B) : '0);
        aq_q[k+1]    <= aq_q[k] | ((ar_q[k] >= at) ? (DW'(1) << B) : '0);
      end
    end
  end

  // bin address and hit decision
  logic          a_hit_q, a_rdok_q;
  logic [AW-1:0] a_addr_q;
  logic          hit_d, rdok_d;
  logic [AW-1:0] bin_d;

  always_comb begin
    hit_d  = (side_q[G_DV].cmd == CMD_EVENT) && side_q[G_DV].pass &&
             !pmiss_q[DW] && !amiss_q[DW];
    rdok_d = (side_q[G_DV].cmd == CMD_READ) &&
             (17'(side_q[G_DV].raddr) < 17'(NBINS));
    bin_d  = AW'(AW'(pq_q[DW][PW-1:0]) * AW'(ANGLE_BINS)) + AW'(aq_q[DW][QW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_hit_q  <= hit_d;
      a_rdok_q <= rdok_d;
      a_addr_q <= hit_d ? bin_d : AW'(side_q[G_DV].raddr);
    end
  end

  // bin memory: count in the upper 32 bits, intensity in the lower 48
  logic [79:0]   mem [NBINS];
  logic [79:0]   rd_q, fwd_data_q, w_old, w_new;
  logic          fwd_q;
  logic          w_hit_q, w_rdok_q;
  logic [AW-1:0] w_addr_q;
  logic [31:0]   old_cnt;
  logic [47:0]   old_int;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [79:0]   mem_wd;

  assign w_old   = fwd_q ? fwd_data_q : rd_q;
  assign old_cnt = w_old[79:48];
  assign old_int = w_old[47:0];

  always_comb begin
    w_new[79:48] = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + 32'd1;
    w_new[47:0]  = (old_int > INT_MAX - 48'(side_q[G_W].add)) ? INT_MAX :
                   old_int + 48'(side_q[G_W].add);
    mem_we = clr_q || (adv && vld_q[G_W] && w_hit_q);
    mem_wa = clr_q ? clr_cnt_q : w_addr_q;
    mem_wd = clr_q ? '0 : w_new;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // read with forwarding of the bin being written this cycle
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q       <= mem[a_addr_q];
      fwd_q      <= vld_q[G_W] && w_hit_q && (w_addr_q == a_addr_q);
      fwd_data_q <= w_new;
      w_hit_q    <= a_hit_q;
      w_rdok_q   <= a_rdok_q;
      w_addr_q   <= a_addr_q;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(NBINS - 1)) clr_q <= 1'b0;
    end
  end

  // output register
  logic        o_fwd_q, o_reg_q;
  logic [31:0] o_cnt_q;
  logic [47:0] o_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (adv) o_vld_q <= vld_q[G_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_fwd_q <= 1'b0;
      o_reg_q <= 1'b0;
      o_cnt_q <= '0;
      o_int_q <= '0;
      case (side_q[G_W].cmd)
        CMD_EVENT: begin
          o_fwd_q <= !mode_q[2] || w_hit_q;
          o_reg_q <= w_hit_q;
        end
        CMD_BLOCK: o_fwd_q <= 1'b1;
        CMD_READ: begin
          if (w_rdok_q) begin
            o_cnt_q <= old_cnt;
            o_int_q <= old_int;
          end
        end
        default: o_fwd_q <= 1'b0;
      endcase
    end
  end

  assign out_valid_o      = o_vld_q;
  assign forward_o        = o_fwd_q;
  assign registered_o     = o_reg_q;
  assign read_count_o     = o_cnt_q;
  assign read_intensity_o = o_int_q;

  // checks
  `PDH_ASSERT_NEVER(a_clear_empty, clk_i, rst_ni, clr_q && (o_vld_q || vld_q[0]))
  `PDH_ASSERT_IMPLY(a_reg_fwd, clk_i, rst_ni, out_valid_o && registered_o, forward_o)
  `PDH_ASSERT_IMPLY(a_stall_nowr, clk_i, rst_ni, !adv, !mem_we)
  `PDH_ASSERT_IMPLY(a_read_zero, clk_i, rst_ni, out_valid_o && (forward_o || registered_o), (read_count_o == '0) && (read_intensity_o == '0))

endmodule
